// ----- hdl/rnes_pkg.sv -----
// ============================================================================
// rnes_pkg: shared types and constants for the ring neighbor energy sum
// Ring size, field widths, register indexes and the count bundle that
// travels from the count stage into the multiply-accumulate lanes.
// ============================================================================
`default_nettype none

package rnes_pkg;

    // Ring geometry and field widths
    localparam int RING_SITES = 16;
    localparam int OCC_W      = 16;
    localparam int COEF_W     = 32;
    localparam int SUM_W      = 40;
    localparam int CNT_W      = $clog2(RING_SITES + 1);
    localparam int PROD_W     = COEF_W + CNT_W + 1;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ENERGY       = 3'd0,
        REG_ISOLATED_ENERGY   = 3'd1,
        REG_EDGE_ENERGY       = 3'd2,
        REG_INNER_ENERGY      = 3'd3,
        REG_BASE_ENTHALPY     = 3'd4,
        REG_ISOLATED_ENTHALPY = 3'd5,
        REG_EDGE_ENTHALPY     = 3'd6,
        REG_INNER_ENTHALPY    = 3'd7
    } cfg_idx_t;

    // Site counts per neighbor class
    typedef struct packed {
        logic [CNT_W-1:0] n_occ;
        logic [CNT_W-1:0] n_isolated;
        logic [CNT_W-1:0] n_edge;
        logic [CNT_W-1:0] n_inner;
    } cnt_t;

    // Stage advance strobes for the accumulate lanes
    typedef struct packed {
        logic adv_mul;
        logic adv_sum;
    } mac_ctrl_t;

    // Map the input pattern onto the ring; sites past the input are empty
    function automatic logic [RING_SITES-1:0] ring_bits(input logic [OCC_W-1:0] pattern);
        logic [OCC_W+RING_SITES-1:0] wide;
        wide = {{RING_SITES{1'b0}}, pattern};
        return wide[RING_SITES-1:0];
    endfunction

    // Population count of a ring-wide mask
    function automatic logic [CNT_W-1:0] popcount(input logic [RING_SITES-1:0] mask);
        logic [CNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < RING_SITES; i++)
        begin
            acc = acc + CNT_W'(mask[i]);
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rnes_mac.sv -----
// ============================================================================
// rnes_mac: weighted sum of the class counts for one quantity
// Multiplies each class count by its coefficient in one stage, then adds
// the four products into the 40-bit result in the next stage.
// ============================================================================
`default_nettype none

module rnes_mac (
    input  wire logic                         clk,
    input  wire rnes_pkg::mac_ctrl_t          ctrl,
    input  wire rnes_pkg::cnt_t               cnt,
    input  wire logic signed [31:0]           coef_base,
    input  wire logic signed [31:0]           coef_isolated,
    input  wire logic signed [31:0]           coef_edge,
    input  wire logic signed [31:0]           coef_inner,
    output logic signed [39:0]                sum
);
    import rnes_pkg::*;

    logic signed [PROD_W-1:0] prod_base_reg,  prod_base_next;
    logic signed [PROD_W-1:0] prod_iso_reg,   prod_iso_next;
    logic signed [PROD_W-1:0] prod_edge_reg,  prod_edge_next;
    logic signed [PROD_W-1:0] prod_inner_reg, prod_inner_next;
    logic signed [SUM_W-1:0]  sum_reg,        sum_next;

    // Multiply each count (unsigned) by its signed coefficient
    always_comb
    begin
        prod_base_next  = PROD_W'(coef_base)     * $signed(PROD_W'(cnt.n_occ));
        prod_iso_next   = PROD_W'(coef_isolated) * $signed(PROD_W'(cnt.n_isolated));
        prod_edge_next  = PROD_W'(coef_edge)     * $signed(PROD_W'(cnt.n_edge));
        prod_inner_next = PROD_W'(coef_inner)    * $signed(PROD_W'(cnt.n_inner));
    end

    // Add the four sign-extended products
    always_comb
    begin
        sum_next = SUM_W'(prod_base_reg) + SUM_W'(prod_iso_reg)
                 + SUM_W'(prod_edge_reg) + SUM_W'(prod_inner_reg);
    end

    // Hold product and sum registers while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (ctrl.adv_mul)
        begin
            prod_base_reg  <= prod_base_next;
            prod_iso_reg   <= prod_iso_next;
            prod_edge_reg  <= prod_edge_next;
            prod_inner_reg <= prod_inner_next;
        end
        if (ctrl.adv_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ----- hdl/ring_neighbor_energy_sum.sv -----
// An accepted request passes the classify, count, multiply and add stage
// registers to out_valid. Throughput: one request per cycle when not stalled;
// the four stages each advance whenever the stage after them is empty or moving.
// Reset: clears all stage valid bits and the eight coefficient registers.
// in_stall rises only when every stage is full and out_stall is high.
// ============================================================================
// ring_neighbor_energy_sum: summed free energy and enthalpy of a ring pattern
// Classifies each occupied site by its two ring neighbors, counts the
// classes and forms the weighted Q24.16 sums of both quantities.
// ============================================================================
`default_nettype none

module ring_neighbor_energy_sum (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rnes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [15:0]                     site_occupancy,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [39:0]                   free_energy,
    output logic signed [39:0]                   total_enthalpy
);
    import rnes_pkg::*;

    logic [COEF_W-1:0] cfg_reg [NUM_REGS];

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [RING_SITES-1:0] iso_reg,   iso_next;
    logic [RING_SITES-1:0] edg_reg,   edg_next;
    logic [RING_SITES-1:0] inner_reg, inner_next;
    logic [RING_SITES-1:0] occ_vec;
    cnt_t                  cnt_reg,   cnt_next;
    mac_ctrl_t             mac_ctrl;

    // Write coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Stage ready chain: a stage advances when empty or when its successor moves
    always_comb
    begin
        rdy4     = !s4_valid_reg || !out_stall;
        rdy3     = !s3_valid_reg || rdy4;
        rdy2     = !s2_valid_reg || rdy3;
        rdy1     = !s1_valid_reg || rdy2;
        in_stall = !rdy1;
        mac_ctrl.adv_mul = rdy3;
        mac_ctrl.adv_sum = rdy4;
    end

    // Classify each occupied site by the occupancy of its two ring neighbors
    always_comb
    begin
        logic [1:0] nb;
        int         lft;
        int         rgt;
        occ_vec    = ring_bits(site_occupancy);
        iso_next   = '0;
        edg_next   = '0;
        inner_next = '0;
        for (int k = 0; k < RING_SITES; k++)
        begin
            lft = (k == 0) ? RING_SITES - 1 : k - 1;
            rgt = (k == RING_SITES - 1) ? 0 : k + 1;
            nb  = 2'(occ_vec[lft]) + 2'(occ_vec[rgt]);
            iso_next[k]   = occ_vec[k] && (nb == 2'd0);
            edg_next[k]   = occ_vec[k] && (nb == 2'd1);
            inner_next[k] = occ_vec[k] && (nb == 2'd2);
        end
    end

    // Count sites in each class
    always_comb
    begin
        cnt_next.n_isolated = popcount(iso_reg);
        cnt_next.n_edge     = popcount(edg_reg);
        cnt_next.n_inner    = popcount(inner_reg);
        cnt_next.n_occ      = popcount(iso_reg | edg_reg | inner_reg);
    end

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Hold stage payloads while stalled
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            iso_reg   <= iso_next;
            edg_reg   <= edg_next;
            inner_reg <= inner_next;
        end
        if (rdy2)
        begin
            cnt_reg <= cnt_next;
        end
    end

    rnes_mac u_mac_energy (
        .clk           (clk),
        .ctrl          (mac_ctrl),
        .cnt           (cnt_reg),
        .coef_base     ($signed(cfg_reg[REG_BASE_ENERGY])),
        .coef_isolated ($signed(cfg_reg[REG_ISOLATED_ENERGY])),
        .coef_edge     ($signed(cfg_reg[REG_EDGE_ENERGY])),
        .coef_inner    ($signed(cfg_reg[REG_INNER_ENERGY])),
        .sum           (free_energy)
    );

    rnes_mac u_mac_enthalpy (
        .clk           (clk),
        .ctrl          (mac_ctrl),
        .cnt           (cnt_reg),
        .coef_base     ($signed(cfg_reg[REG_BASE_ENTHALPY])),
        .coef_isolated ($signed(cfg_reg[REG_ISOLATED_ENTHALPY])),
        .coef_edge     ($signed(cfg_reg[REG_EDGE_ENTHALPY])),
        .coef_inner    ($signed(cfg_reg[REG_INNER_ENTHALPY])),
        .sum           (total_enthalpy)
    );

    assign out_valid = s4_valid_reg;

    // Input is held off only when the whole pipe is full and the output stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                      && s4_valid_reg && out_stall))
        else $error("input stalled while pipeline has room");

    // Every occupied site falls into exactly one neighbor class
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (CNT_W'(cnt_reg.n_isolated + cnt_reg.n_edge + cnt_reg.n_inner)
                          == cnt_reg.n_occ))
        else $error("class counts do not add up to occupied sites");

    // A full multiply stage that cannot advance keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !rdy3) |=> s3_valid_reg)
        else $error("multiply stage dropped a request under stall");

    // A configuration write lands in the addressed register
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (cfg_reg[$past(cfg_index)] == $past(cfg_data)))
        else $error("coefficient register write lost");

endmodule

`default_nettype wire
